// ----- hdl/tsps_pkg.sv -----
// shared types and constants of the time slice process scheduler
package tsps_pkg;

  localparam int JOB_SLOTS       = 16;
  localparam int BURST_BITS      = 16;
  localparam int SLOT_FIELD_BITS = 4;
  localparam int CNT_BITS        = $clog2(JOB_SLOTS + 1);
  localparam int TIME_BITS       = 32;
  localparam int SWITCH_BITS     = 16;
  localparam int QUANTUM_BITS    = 16;
  localparam int STATUS_BITS     = 3;
  localparam int CFG_IDX_BITS    = 1;
  localparam int CFG_DATA_BITS   = 16;

  typedef enum logic {
    CMD_ARRIVE = 1'b0,
    CMD_TICK   = 1'b1
  } cmd_t;

  typedef enum logic [STATUS_BITS-1:0] {
    ST_ACCEPTED  = 3'd0,
    ST_REJECTED  = 3'd1,
    ST_IDLE_TICK = 3'd2,
    ST_RAN       = 3'd3,
    ST_FINISHED  = 3'd4
  } status_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_POLICY_MODE = 1'b0,
    CFG_QUANTUM_LEN = 1'b1
  } cfg_reg_t;

  // one queued job with its bookkeeping
  typedef struct packed {
    logic [SLOT_FIELD_BITS-1:0] slot;
    logic [BURST_BITS-1:0]      remaining;
    logic [BURST_BITS-1:0]      burst;
    logic [TIME_BITS-1:0]       arrival;
    logic [TIME_BITS-1:0]       start;
    logic                       started;
    logic [SWITCH_BITS-1:0]     preempt;
  } job_entry_t;

  typedef struct packed {
    cmd_t                       command;
    logic [SLOT_FIELD_BITS-1:0] job_slot;
    logic [BURST_BITS-1:0]      burst_len;
  } sched_item_t;

  typedef struct packed {
    status_t                    status;
    logic [SLOT_FIELD_BITS-1:0] job_id;
    logic [TIME_BITS-1:0]       now_time;
    logic [TIME_BITS-1:0]       turnaround;
    logic [TIME_BITS-1:0]       wait_time;
    logic [TIME_BITS-1:0]       response;
    logic [SWITCH_BITS-1:0]     switch_count;
  } sched_result_t;

  typedef struct packed {
    logic                    policy_mode;
    logic [QUANTUM_BITS-1:0] quantum_len;
  } sched_cfg_t;

endpackage

// ----- hdl/tsps_intf.sv -----
// channel interfaces of the time slice process scheduler
interface tsps_in_if import tsps_pkg::*; ;
  logic                       valid;
  logic                       ready;
  logic                       command;
  logic [SLOT_FIELD_BITS-1:0] job_slot;
  logic [BURST_BITS-1:0]      burst_len;

  modport source (output valid, command, job_slot, burst_len, input ready);
  modport sink (input valid, command, job_slot, burst_len, output ready);
endinterface

interface tsps_out_if import tsps_pkg::*; ;
  logic                       valid;
  logic                       ready;
  logic [STATUS_BITS-1:0]     status;
  logic [SLOT_FIELD_BITS-1:0] job_id;
  logic [TIME_BITS-1:0]       now_time;
  logic [TIME_BITS-1:0]       turnaround;
  logic [TIME_BITS-1:0]       wait_time;
  logic [TIME_BITS-1:0]       response;
  logic [SWITCH_BITS-1:0]     switch_count;

  modport source (output valid, status, job_id, now_time, turnaround, wait_time, response,
                  switch_count, input ready);
  modport sink (input valid, status, job_id, now_time, turnaround, wait_time, response,
                switch_count, output ready);
endinterface

interface tsps_cfg_if import tsps_pkg::*; ;
  logic                     valid;
  logic                     ready;
  logic [CFG_IDX_BITS-1:0]  index;
  logic [CFG_DATA_BITS-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- hdl/tsps_core.sv -----
// scheduler state and the single-pass update for one transaction
module tsps_core import tsps_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          step_en,
  input  sched_item_t   item,
  input  sched_cfg_t    cfg,
  output sched_result_t result
);

  job_entry_t                 job_q_r   [JOB_SLOTS];
  job_entry_t                 job_q_nxt [JOB_SLOTS];
  job_entry_t                 shift_q   [JOB_SLOTS];
  job_entry_t                 rot_q     [JOB_SLOTS];
  job_entry_t                 pop_q     [JOB_SLOTS];
  logic [CNT_BITS-1:0]        job_cnt_r, job_cnt_nxt;
  logic [JOB_SLOTS-1:0]       slot_busy_r, slot_busy_nxt;
  logic [TIME_BITS-1:0]       time_now_r, time_now_nxt;
  logic [QUANTUM_BITS-1:0]    slice_used_r, slice_used_nxt;
  logic                       rotate_pending_r, rotate_pending_nxt;

  logic                       is_tick;
  logic                       do_rotate;
  logic                       has_job;
  logic                       slot_ok;
  logic                       finishing;
  job_entry_t                 rot_head;
  job_entry_t                 head;
  job_entry_t                 new_job;
  job_entry_t                 ran_job;
  logic [TIME_BITS-1:0]       time_inc;
  logic [TIME_BITS-1:0]       head_start;
  logic [TIME_BITS-1:0]       turn;
  logic [TIME_BITS-1:0]       burst_ext;
  logic [QUANTUM_BITS-1:0]    slice_base;
  logic [QUANTUM_BITS-1:0]    slice_inc;

  assign is_tick   = (item.command == CMD_TICK);
  assign has_job   = (job_cnt_r != '0);
  assign do_rotate = is_tick && rotate_pending_r && cfg.policy_mode && has_job;
  assign slot_ok   = (32'(item.job_slot) < 32'(JOB_SLOTS)) && !slot_busy_r[item.job_slot];

  // queue moved down by one place
  always_comb begin
    for (int i = 0; i < JOB_SLOTS - 1; i++) begin
      shift_q[i] = job_q_r[i + 1];
    end
    shift_q[JOB_SLOTS-1] = job_q_r[JOB_SLOTS-1];
  end

  // old head goes to the tail, counted only when others wait
  always_comb begin
    rot_head = job_q_r[0];
    if ((job_cnt_r > CNT_BITS'(1)) && (rot_head.preempt != '1)) begin
      rot_head.preempt = rot_head.preempt + SWITCH_BITS'(1);
    end
    for (int i = 0; i < JOB_SLOTS; i++) begin
      if (do_rotate) begin
        rot_q[i] = (CNT_BITS'(i + 1) == job_cnt_r) ? rot_head : shift_q[i];
      end else begin
        rot_q[i] = job_q_r[i];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < JOB_SLOTS - 1; i++) begin
      pop_q[i] = rot_q[i + 1];
    end
    pop_q[JOB_SLOTS-1] = rot_q[JOB_SLOTS-1];
  end

  assign head       = rot_q[0];
  assign head_start = head.started ? head.start : time_now_r;
  assign time_inc   = time_now_r + TIME_BITS'(1);
  assign slice_base = rotate_pending_r ? '0 : slice_used_r;
  assign slice_inc  = (slice_base == '1) ? slice_base : slice_base + QUANTUM_BITS'(1);
  assign finishing  = (head.remaining <= BURST_BITS'(1));
  assign turn       = time_inc - head.arrival;
  assign burst_ext  = TIME_BITS'(head.burst);

  always_comb begin
    new_job.slot      = item.job_slot;
    new_job.remaining = item.burst_len;
    new_job.burst     = item.burst_len;
    new_job.arrival   = time_now_r;
    new_job.start     = '0;
    new_job.started   = 1'b0;
    new_job.preempt   = '0;

    ran_job           = head;
    ran_job.remaining = head.remaining - BURST_BITS'(1);
    ran_job.start     = head_start;
    ran_job.started   = 1'b1;
  end

  always_comb begin
    job_q_nxt          = job_q_r;
    job_cnt_nxt        = job_cnt_r;
    slot_busy_nxt      = slot_busy_r;
    time_now_nxt       = time_now_r;
    slice_used_nxt     = slice_used_r;
    rotate_pending_nxt = rotate_pending_r;
    result             = '0;
    result.status      = ST_IDLE_TICK;

    if (!is_tick) begin
      result.job_id   = item.job_slot;
      result.now_time = time_now_r;
      if (slot_ok && (job_cnt_r < CNT_BITS'(JOB_SLOTS))) begin
        slot_busy_nxt[item.job_slot]                 = 1'b1;
        job_q_nxt[job_cnt_r[SLOT_FIELD_BITS-1:0]]    = new_job;
        job_cnt_nxt                                  = job_cnt_r + CNT_BITS'(1);
        result.status                                = ST_ACCEPTED;
      end else begin
        result.status = ST_REJECTED;
      end
    end else begin
      rotate_pending_nxt = 1'b0;
      time_now_nxt       = time_inc;
      result.now_time    = time_inc;
      job_q_nxt          = rot_q;
      if (!has_job) begin
        slice_used_nxt = slice_base;
        result.status  = ST_IDLE_TICK;
      end else begin
        result.job_id = head.slot;
        if (finishing) begin
          job_q_nxt                 = pop_q;
          job_cnt_nxt               = job_cnt_r - CNT_BITS'(1);
          slot_busy_nxt[head.slot]  = 1'b0;
          slice_used_nxt            = '0;
          result.status             = ST_FINISHED;
          result.turnaround         = turn;
          result.wait_time          = (turn > burst_ext) ? (turn - burst_ext) : '0;
          result.response           = head_start - head.arrival;
          result.switch_count       = head.preempt;
        end else begin
          job_q_nxt[0]       = ran_job;
          slice_used_nxt     = slice_inc;
          result.status      = ST_RAN;
          rotate_pending_nxt = cfg.policy_mode && (slice_inc >= cfg.quantum_len);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      job_cnt_r        <= '0;
      slot_busy_r      <= '0;
      time_now_r       <= '0;
      slice_used_r     <= '0;
      rotate_pending_r <= 1'b0;
    end else if (step_en) begin
      job_cnt_r        <= job_cnt_nxt;
      slot_busy_r      <= slot_busy_nxt;
      time_now_r       <= time_now_nxt;
      slice_used_r     <= slice_used_nxt;
      rotate_pending_r <= rotate_pending_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en) begin
      job_q_r <= job_q_nxt;
    end
  end

endmodule

// ----- hdl/time_slice_process_scheduler.sv -----
// time slice process scheduler top level: round robin with quantum, or first come first served
// an accepted transaction is held in the input register, then written to the result register
// throughput: one transaction per cycle unless the receiver stalls; input register, core
// update and result register form one pass, with state written back in that same cycle
// reset (rst_n low, synchronous): queue empty, all slots free, time and slice zero,
// round robin mode with quantum 4, no transaction held in either register
module time_slice_process_scheduler import tsps_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  tsps_in_if.sink   in_ch,
  tsps_out_if.source out_ch,
  tsps_cfg_if.sink  cfg_ch
);

  // input register
  sched_item_t   item_r;
  logic          item_vld_r;

  // result register
  sched_result_t res_r;
  logic          res_vld_r;
  sched_result_t res_nxt;

  // configuration registers
  sched_cfg_t    cfg_r;

  // held item moves on when the result register is free or being drained
  logic          advance;

  assign advance     = item_vld_r && (!res_vld_r || out_ch.ready);
  assign in_ch.ready = !item_vld_r || advance;

  // config writes are always taken; the user keeps the block idle when they arrive (unchecked)
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.policy_mode <= 1'b1;
      cfg_r.quantum_len <= QUANTUM_BITS'(4);
    end else if (cfg_ch.valid) begin
      if (cfg_ch.index == CFG_POLICY_MODE) begin
        cfg_r.policy_mode <= cfg_ch.data[0];
      end
      if (cfg_ch.index == CFG_QUANTUM_LEN) begin
        cfg_r.quantum_len <= cfg_ch.data[QUANTUM_BITS-1:0];
      end
    end
  end

  // input stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
    end else if (in_ch.ready) begin
      item_vld_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      item_r.command   <= cmd_t'(in_ch.command);
      item_r.job_slot  <= in_ch.job_slot;
      item_r.burst_len <= in_ch.burst_len;
    end
  end

  // queue, per-job bookkeeping and the single-pass update
  tsps_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (advance),
    .item    (item_r),
    .cfg     (cfg_r),
    .result  (res_nxt)
  );

  // result stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_vld_r <= 1'b0;
    end else if (advance) begin
      res_vld_r <= 1'b1;
    end else if (out_ch.ready) begin
      res_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  assign out_ch.valid        = res_vld_r;
  assign out_ch.status       = res_r.status;
  assign out_ch.job_id       = res_r.job_id;
  assign out_ch.now_time     = res_r.now_time;
  assign out_ch.turnaround   = res_r.turnaround;
  assign out_ch.wait_time    = res_r.wait_time;
  assign out_ch.response     = res_r.response;
  assign out_ch.switch_count = res_r.switch_count;

endmodule

// ----- test/testbench.sv -----
// self-checking testbench for the time slice process scheduler
`timescale 1ns / 1ps

module testbench;
  import tsps_pkg::*;

  localparam int PIPE_LATENCY = 2;
  localparam int IDLE_LIMIT   = 500;   // cycles without any transaction before giving up
  localparam int HOLD_CYCLES  = 60;    // long receiver hold-off
  localparam int PHASES       = 8;
  localparam int PHASE_ITEMS  = 200;
  localparam int DIR_ROWS     = 21;

  typedef enum logic {
    ROW_JOB,
    ROW_REG
  } row_kind_t;

  // one line of the directed table: either a job transaction or a register write
  typedef struct packed {
    row_kind_t          kind;
    sched_item_t        item;
    cfg_reg_t           reg_idx;
    logic [15:0]        reg_data;
    logic               typed;    // outcome given here instead of computed
    sched_result_t      outcome;
  } dir_row_t;

  localparam sched_result_t NO_OUTCOME = '0;
  localparam sched_item_t   NO_ITEM    = '0;

  logic clk;
  logic rst_n;

  tsps_in_if  in_ch ();
  tsps_out_if out_ch ();
  tsps_cfg_if cfg_ch ();

  time_slice_process_scheduler i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // scheduler mirror: configuration
  logic                   pol_rr;
  logic [QUANTUM_BITS-1:0] slice_len;

  // scheduler mirror: ready queue and per-slot bookkeeping
  logic [SLOT_FIELD_BITS-1:0] run_queue [JOB_SLOTS];
  int                         rq_head;
  int                         rq_tail;
  int                         rq_count;
  logic                       slot_taken  [JOB_SLOTS];
  logic [BURST_BITS-1:0]      work_left   [JOB_SLOTS];
  logic [BURST_BITS-1:0]      burst_of    [JOB_SLOTS];
  logic [TIME_BITS-1:0]       arrived_at  [JOB_SLOTS];
  logic [TIME_BITS-1:0]       started_at  [JOB_SLOTS];
  logic                       got_cpu     [JOB_SLOTS];
  logic [SWITCH_BITS-1:0]     preempts    [JOB_SLOTS];
  logic [TIME_BITS-1:0]       clock_now;
  logic [QUANTUM_BITS-1:0]    slice_run;
  logic                       rotate_due;

  // outcomes still owed by the block, oldest first
  sched_result_t sched_outcomes [$];
  int            err_count = 0;
  bit            hold_req  = 0;

  // directed part: reset values, zero burst, busy slot, extreme burst, fresh arrivals
  // ahead of a pending rotation, switch to fcfs with a rotation pending, largest and
  // zero quantum
  dir_row_t dir_table [DIR_ROWS] = '{
    // tick on an empty queue still advances time
    '{ROW_JOB, '{CMD_TICK, 4'hA, 16'hFFFF}, CFG_POLICY_MODE, 16'd0, 1'b1,
      '{ST_IDLE_TICK, 4'd0, 32'd1, 32'd0, 32'd0, 32'd0, 16'd0}},
    // zero burst
    '{ROW_JOB, '{CMD_ARRIVE, 4'd0, 16'd0}, CFG_POLICY_MODE, 16'd0, 1'b1,
      '{ST_ACCEPTED, 4'd0, 32'd1, 32'd0, 32'd0, 32'd0, 16'd0}},
    // slot already in use
    '{ROW_JOB, '{CMD_ARRIVE, 4'd0, 16'hFFFF}, CFG_POLICY_MODE, 16'd0, 1'b1,
      '{ST_REJECTED, 4'd0, 32'd1, 32'd0, 32'd0, 32'd0, 16'd0}},
    // zero burst runs as one unit
    '{ROW_JOB, '{CMD_TICK, 4'h5, 16'h1234}, CFG_POLICY_MODE, 16'd0, 1'b1,
      '{ST_FINISHED, 4'd0, 32'd2, 32'd1, 32'd1, 32'd0, 16'd0}},
    '{ROW_JOB, '{CMD_ARRIVE, 4'd15, 16'd9}, CFG_POLICY_MODE, 16'd0, 1'b1,
      '{ST_ACCEPTED, 4'd15, 32'd2, 32'd0, 32'd0, 32'd0, 16'd0}},
    '{ROW_JOB, '{CMD_ARRIVE, 4'd3, 16'd2}, CFG_POLICY_MODE, 16'd0, 1'b1,
      '{ST_ACCEPTED, 4'd3, 32'd2, 32'd0, 32'd0, 32'd0, 16'd0}},
    '{ROW_REG, NO_ITEM, CFG_QUANTUM_LEN, 16'd1, 1'b0, NO_OUTCOME},
    '{ROW_JOB, '{CMD_TICK, 4'd0, 16'd0}, CFG_POLICY_MODE, 16'd0, 1'b0, NO_OUTCOME},
    // arrives while a rotation is pending, so it queues ahead of the rotated job
    '{ROW_JOB, '{CMD_ARRIVE, 4'd7, 16'd1}, CFG_POLICY_MODE, 16'd0, 1'b1,
      '{ST_ACCEPTED, 4'd7, 32'd3, 32'd0, 32'd0, 32'd0, 16'd0}},
    '{ROW_JOB, '{CMD_TICK, 4'd0, 16'd0}, CFG_POLICY_MODE, 16'd0, 1'b0, NO_OUTCOME},
    '{ROW_JOB, '{CMD_TICK, 4'd0, 16'd0}, CFG_POLICY_MODE, 16'd0, 1'b0, NO_OUTCOME},
    '{ROW_JOB, '{CMD_TICK, 4'd0, 16'd0}, CFG_POLICY_MODE, 16'd0, 1'b0, NO_OUTCOME},
    // fcfs while a rotation is pending drops it; upper data bits are don't-care
    '{ROW_REG, NO_ITEM, CFG_POLICY_MODE, 16'hFFFE, 1'b0, NO_OUTCOME},
    '{ROW_JOB, '{CMD_TICK, 4'd0, 16'd0}, CFG_POLICY_MODE, 16'd0, 1'b0, NO_OUTCOME},
    '{ROW_REG, NO_ITEM, CFG_POLICY_MODE, 16'h0001, 1'b0, NO_OUTCOME},
    '{ROW_REG, NO_ITEM, CFG_QUANTUM_LEN, 16'hFFFF, 1'b0, NO_OUTCOME},
    '{ROW_JOB, '{CMD_TICK, 4'd0, 16'd0}, CFG_POLICY_MODE, 16'd0, 1'b0, NO_OUTCOME},
    // zero quantum acts as one
    '{ROW_REG, NO_ITEM, CFG_QUANTUM_LEN, 16'd0, 1'b0, NO_OUTCOME},
    '{ROW_JOB, '{CMD_TICK, 4'd0, 16'd0}, CFG_POLICY_MODE, 16'd0, 1'b0, NO_OUTCOME},
    '{ROW_JOB, '{CMD_TICK, 4'd0, 16'd0}, CFG_POLICY_MODE, 16'd0, 1'b0, NO_OUTCOME},
    '{ROW_JOB, '{CMD_ARRIVE, 4'd8, 16'd3}, CFG_POLICY_MODE, 16'd0, 1'b0, NO_OUTCOME}
  };

  // settings of the random phases, extremes among them
  logic                    phase_rr      [PHASES] = '{1'b1, 1'b0, 1'b1, 1'b1,
                                                      1'b0, 1'b1, 1'b1, 1'b1};
  logic [QUANTUM_BITS-1:0] phase_quantum [PHASES] = '{16'd3, 16'd9, 16'd1, 16'hFFFF,
                                                      16'd0, 16'd0, 16'd2, 16'd5};

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ready queue of the mirror
  function automatic void queue_push(logic [SLOT_FIELD_BITS-1:0] slot);
    if (rq_count >= JOB_SLOTS) return;
    run_queue[rq_tail] = slot;
    rq_tail  = (rq_tail + 1) % JOB_SLOTS;
    rq_count = rq_count + 1;
  endfunction

  function automatic logic [SLOT_FIELD_BITS-1:0] queue_pop();
    logic [SLOT_FIELD_BITS-1:0] slot;
    slot     = run_queue[rq_head];
    rq_head  = (rq_head + 1) % JOB_SLOTS;
    rq_count = rq_count - 1;
    return slot;
  endfunction

  // advance the mirror by one transaction and return the outcome it owes
  function automatic sched_result_t scheduler_step(sched_item_t it);
    sched_result_t              res;
    logic [SLOT_FIELD_BITS-1:0] h;
    logic [SLOT_FIELD_BITS-1:0] r;
    logic [QUANTUM_BITS-1:0]    q;
    logic [TIME_BITS-1:0]       turn;
    res = '0;

    if (it.command == CMD_ARRIVE) begin
      res.job_id = it.job_slot;
      if (slot_taken[it.job_slot]) begin
        res.status = ST_REJECTED;
      end else begin
        slot_taken[it.job_slot] = 1'b1;
        work_left[it.job_slot]  = it.burst_len;
        burst_of[it.job_slot]   = it.burst_len;
        arrived_at[it.job_slot] = clock_now;
        got_cpu[it.job_slot]    = 1'b0;
        preempts[it.job_slot]   = '0;
        queue_push(it.job_slot);
        res.status = ST_ACCEPTED;
      end
      res.now_time = clock_now;
      return res;
    end

    // a used-up slice rotates now, after any arrivals since the last tick
    if (rotate_due) begin
      rotate_due = 1'b0;
      slice_run  = '0;
      if (pol_rr && rq_count > 0) begin
        r = queue_pop();
        if (rq_count > 0 && preempts[r] != '1) preempts[r] = preempts[r] + 1'b1;
        queue_push(r);
      end
    end

    if (rq_count == 0) begin
      clock_now    = clock_now + 1;
      res.status   = ST_IDLE_TICK;
      res.now_time = clock_now;
      return res;
    end

    h = run_queue[rq_head];
    q = (slice_len == '0) ? QUANTUM_BITS'(1) : slice_len;
    res.job_id = h;
    if (!got_cpu[h]) begin
      got_cpu[h]    = 1'b1;
      started_at[h] = clock_now;
    end
    clock_now = clock_now + 1;
    if (slice_run != '1) slice_run = slice_run + 1'b1;
    if (work_left[h] <= 1) begin
      turn          = clock_now - arrived_at[h];
      work_left[h]  = '0;
      void'(queue_pop());
      slot_taken[h] = 1'b0;
      slice_run     = '0;
      rotate_due    = 1'b0;
      res.status       = ST_FINISHED;
      res.turnaround   = turn;
      res.wait_time    = (turn > TIME_BITS'(burst_of[h])) ? turn - TIME_BITS'(burst_of[h]) : '0;
      res.response     = started_at[h] - arrived_at[h];
      res.switch_count = preempts[h];
    end else begin
      work_left[h] = work_left[h] - 1'b1;
      res.status   = ST_RAN;
      if (pol_rr && slice_run >= q) rotate_due = 1'b1;
    end
    res.now_time = clock_now;
    return res;
  endfunction

  // offer one job transaction, hold it until taken, then book its outcome
  task automatic send_job(sched_item_t it, logic typed, sched_result_t given);
    sched_result_t res;
    @(negedge clk);
    in_ch.valid     <= 1'b1;
    in_ch.command   <= it.command;
    in_ch.job_slot  <= it.job_slot;
    in_ch.burst_len <= it.burst_len;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    res = scheduler_step(it);
    sched_outcomes.push_back(typed ? given : res);
  endtask

  task automatic idle_input(int cycles);
    repeat (cycles) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
    end
  endtask

  // hold the sender until every outcome has come back
  task automatic drain_outcomes();
    idle_input(1);
    while (sched_outcomes.size() != 0) @(posedge clk);
  endtask

  // register write, only with the block idle
  task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_BITS-1:0] data);
    drain_outcomes();
    repeat (PIPE_LATENCY + 2) @(posedge clk);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    if (idx == CFG_POLICY_MODE) pol_rr = data[0];
    else slice_len = data;
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic compare_field(string name, logic [31:0] want_v, logic [31:0] got_v);
    if (want_v !== got_v) begin
      $error("%s mismatch: expected %0d, got %0d", name, want_v, got_v);
      err_count++;
    end
  endtask

  // result checker: every accepted transaction against the oldest outcome
  always @(posedge clk) begin
    sched_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (sched_outcomes.size() == 0) begin
        $error("unexpected result: status %0d job %0d time %0d",
               out_ch.status, out_ch.job_id, out_ch.now_time);
        err_count++;
      end else begin
        want = sched_outcomes.pop_front();
        compare_field("status", 32'(want.status), 32'(out_ch.status));
        compare_field("job_id", 32'(want.job_id), 32'(out_ch.job_id));
        compare_field("now_time", want.now_time, out_ch.now_time);
        compare_field("turnaround", want.turnaround, out_ch.turnaround);
        compare_field("wait_time", want.wait_time, out_ch.wait_time);
        compare_field("response", want.response, out_ch.response);
        compare_field("switch_count", 32'(want.switch_count), 32'(out_ch.switch_count));
      end
    end
  end

  // receiver: short random stalls, some long ones, free-running stretches,
  // and one long hold-off on request
  initial begin
    int stall_left;
    int cyc;
    bit free_run;
    stall_left   = 0;
    cyc          = 0;
    free_run     = 1'b0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      cyc++;
      if (cyc % 400 == 0) free_run = !free_run;
      if (hold_req) begin
        // block fills up and must stall its input
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_req = 1'b0;
      end else if (free_run) begin
        out_ch.ready <= 1'b1;
      end else if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else if ($urandom_range(0, 3) != 0) begin
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= 1'b0;
        stall_left = ($urandom_range(0, 19) == 0) ? $urandom_range(4, 24) : $urandom_range(0, 1);
      end
    end
  end

  // watchdog: too long without any transaction on any channel
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("testbench NOT OK");
    $finish;
  end

  // stimulus
  initial begin
    sched_item_t it;
    int          free_slots [$];
    int          gap;
    int          rush_left;
    bit          no_gaps;
    int          d;

    // all inputs known from time zero
    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.command   = CMD_ARRIVE;
    in_ch.job_slot  = '0;
    in_ch.burst_len = '0;
    cfg_ch.valid    = 1'b0;
    cfg_ch.index    = CFG_POLICY_MODE;
    cfg_ch.data     = '0;

    // mirror after reset
    pol_rr     = 1'b1;
    slice_len  = 16'd4;
    rq_head    = 0;
    rq_tail    = 0;
    rq_count   = 0;
    clock_now  = '0;
    slice_run  = '0;
    rotate_due = 1'b0;
    for (int s = 0; s < JOB_SLOTS; s++) begin
      run_queue[s]  = '0;
      slot_taken[s] = 1'b0;
      work_left[s]  = '0;
      burst_of[s]   = '0;
      arrived_at[s] = '0;
      started_at[s] = '0;
      got_cpu[s]    = 1'b0;
      preempts[s]   = '0;
    end

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed table
    foreach (dir_table[k]) begin
      if (dir_table[k].kind == ROW_REG) begin
        write_reg(dir_table[k].reg_idx, dir_table[k].reg_data);
      end else begin
        send_job(dir_table[k].item, dir_table[k].typed, dir_table[k].outcome);
        idle_input($urandom_range(0, 2));
      end
    end

    // run off the longest burst so the random part starts with free slots;
    // tick transactions carry junk in the ignored fields
    while (rq_count != 0) begin
      it.command   = CMD_TICK;
      it.job_slot  = SLOT_FIELD_BITS'($urandom);
      it.burst_len = BURST_BITS'($urandom);
      send_job(it, 1'b0, NO_OUTCOME);
    end

    // random phases, each under its own setting
    rush_left = 0;
    for (int ph = 0; ph < PHASES; ph++) begin
      write_reg(CFG_POLICY_MODE, {15'($urandom), phase_rr[ph]});
      write_reg(CFG_QUANTUM_LEN, (ph == PHASES - 1) ? 16'($urandom_range(1, 8))
                                                    : phase_quantum[ph]);
      no_gaps = (ph % 3 == 1);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        it.job_slot  = SLOT_FIELD_BITS'($urandom);
        it.burst_len = BURST_BITS'($urandom);
        // keep the queue moving: mostly ticks once it is crowded
        if ($urandom_range(0, 9) < ((rq_count >= 6) ? 8 : 4)) begin
          it.command = CMD_TICK;
        end else begin
          it.command = CMD_ARRIVE;
          free_slots.delete();
          for (int s = 0; s < JOB_SLOTS; s++)
            if (!slot_taken[s]) free_slots.push_back(s);
          // now and then a slot picked blindly, which may be busy
          if (free_slots.size() != 0 && $urandom_range(0, 9) != 0)
            it.job_slot = 4'(free_slots[$urandom_range(0, free_slots.size() - 1)]);
          d = $urandom_range(0, 19);
          if (d == 0) it.burst_len = '0;
          else if (d == 1) it.burst_len = 16'($urandom_range(9, 40));
          else it.burst_len = 16'($urandom_range(1, 8));
        end
        send_job(it, 1'b0, NO_OUTCOME);

        // receiver holds off while items keep coming back to back
        if (ph == 2 && n == PHASE_ITEMS / 2) begin
          hold_req  = 1'b1;
          rush_left = 40;
        end

        if (rush_left > 0) begin
          rush_left--;
        end else if (!no_gaps) begin
          d = $urandom_range(0, 19);
          if (d < 11) gap = 0;
          else if (d < 18) gap = $urandom_range(1, 3);
          else gap = $urandom_range(6, 30);
          idle_input(gap);
          if ($urandom_range(0, 149) == 0) drain_outcomes();
        end
      end
    end

    // wait out everything owed, then wait on for stray results
    drain_outcomes();
    repeat (PIPE_LATENCY * 4) @(posedge clk);
    if (err_count == 0)
      $display("testbench OK");
    else
      $display("testbench NOT OK");
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/tsps_pkg.sv
hdl/tsps_intf.sv
hdl/tsps_core.sv
hdl/time_slice_process_scheduler.sv
test/testbench.sv
